[design/mpse_pkg.sv]
// shared types and constants for the monochrome stipple span expander
package mpse_pkg;

   localparam int COORD_BITS   = 11;
   localparam int PITCH_BITS   = 13;
   localparam int HEIGHT_BITS  = 6;
   localparam int ORIGIN_BITS  = 5;
   localparam int SLOT_BITS    = 5;
   localparam int WORD_BITS    = 32;
   localparam int WIDTH_BITS   = 9;
   localparam int ADDR_BITS    = 20;
   localparam int PIXEL_BITS   = 25;
   localparam int GROUP_BITS   = 6;
   localparam int COUNT_BITS   = GROUP_BITS + 1;
   localparam int POS_BITS     = GROUP_BITS + 3;
   localparam int END_BITS     = POS_BITS + 1;
   localparam int STEP_BITS    = 4;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 13;

   localparam logic [END_BITS-1:0] POS_LIMIT = END_BITS'(1 << POS_BITS);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_FILL = 1'b1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_LINE_PITCH   = 3'd0,
      CSR_TRANSPARENT  = 3'd1,
      CSR_HEIGHT       = 3'd2,
      CSR_ORIGIN_X     = 3'd3,
      CSR_ORIGIN_Y     = 3'd4
   } csr_index_type;

   localparam logic [PITCH_BITS-1:0]  PITCH_RESET  = 13'd1024;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 6'd1;

   typedef struct packed {
      logic [PITCH_BITS-1:0]  line_pitch;
      logic                   transparent_mode;
      logic [HEIGHT_BITS-1:0] pattern_height;
      logic [ORIGIN_BITS-1:0] origin_x;
      logic [COORD_BITS-1:0]  origin_y;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  base;
      logic [2:0]            offset;
      logic [END_BITS-1:0]   span_end;
      logic [COUNT_BITS-1:0] groups;
      logic [WORD_BITS-1:0]  pattern;
   } span_type;

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_DIVIDE,
      FR_LOOKUP,
      FR_FETCH,
      FR_PUSH
   } front_state_type;

endpackage

[design/mpse_ram.sv]
// generic single write port ram with registered read
module mpse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[design/mpse_front.sv]
// front end: accepts commands, loads rows, finds stipple row and span geometry
module mpse_front #(
   parameter int PATTERN_ROWS = 32,
   parameter int MAX_SPAN     = 504
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  mpse_pkg::cfg_type                        cfg,
   input  logic                                     start,
   output logic                                     busy,
   input  logic                                     command,
   input  logic [mpse_pkg::SLOT_BITS-1:0]           row_slot,
   input  logic [mpse_pkg::WORD_BITS-1:0]           pattern_word,
   input  logic [mpse_pkg::COORD_BITS-1:0]          span_x,
   input  logic [mpse_pkg::COORD_BITS-1:0]          span_y,
   input  logic [mpse_pkg::WIDTH_BITS-1:0]          span_width,
   output logic                                     ram_wr_en,
   output logic [(PATTERN_ROWS > 1 ? $clog2(PATTERN_ROWS) : 1)-1:0] ram_wr_addr,
   output logic [mpse_pkg::WORD_BITS-1:0]           ram_wr_data,
   output logic                                     ram_rd_en,
   output logic [(PATTERN_ROWS > 1 ? $clog2(PATTERN_ROWS) : 1)-1:0] ram_rd_addr,
   input  logic [mpse_pkg::WORD_BITS-1:0]           ram_rd_data,
   output logic                                     push,
   output mpse_pkg::span_type                       push_entry,
   input  logic                                     queue_full
);
   import mpse_pkg::*;

   localparam int ROW_BITS  = PATTERN_ROWS > 1 ? $clog2(PATTERN_ROWS) : 1;
   localparam int HB        = $clog2(PATTERN_ROWS + 1);
   localparam int SPAN_BITS = $clog2(MAX_SPAN + 1);
   localparam int CMP_BITS  = 13;
   localparam int SUM_BITS  = 14;
   localparam int ROWS_CMP  = 9;

   front_state_type state_ff, state_in;
   logic [COORD_BITS-1:0] x_ff, x_in, y_ff, y_in, num_ff, num_in;
   logic [SPAN_BITS-1:0]  w_ff, w_in;
   logic                  neg_ff, neg_in;
   logic [HB-1:0]         rem_ff, rem_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [PIXEL_BITS-1:0] p_ff, p_in;
   logic [WORD_BITS-1:0]  pat_ff, pat_in;

   logic [ROWS_CMP-1:0]   h_cfg;
   logic [HB-1:0]         h_eff;
   logic [HB:0]           shifted;
   logic [HB-1:0]         row_hb;
   logic [CMP_BITS-1:0]   w_wide;
   logic [SPAN_BITS-1:0]  w_sat;
   logic [SUM_BITS-1:0]   end_sum;
   logic [END_BITS-1:0]   end_cap;
   logic [END_BITS:0]     groups_sum;
   logic [ORIGIN_BITS-1:0] rot;
   logic [2*WORD_BITS-1:0] pat_twice;
   logic                  accept;

   always_comb begin
      h_cfg = (cfg.pattern_height == '0) ? ROWS_CMP'(1) : ROWS_CMP'(cfg.pattern_height);
      h_eff = (h_cfg > ROWS_CMP'(PATTERN_ROWS)) ? HB'(PATTERN_ROWS) : HB'(h_cfg);
      w_wide = CMP_BITS'(span_width);
      w_sat  = (w_wide > CMP_BITS'(MAX_SPAN)) ? SPAN_BITS'(MAX_SPAN) : SPAN_BITS'(w_wide);
      shifted = {rem_ff, num_ff[COORD_BITS-1]};
      row_hb  = (neg_ff && rem_ff != '0) ? HB'(h_eff - rem_ff) : rem_ff;
      end_sum = SUM_BITS'(p_ff[2:0]) + SUM_BITS'(w_ff);
      end_cap = (end_sum > SUM_BITS'(POS_LIMIT)) ? POS_LIMIT : END_BITS'(end_sum);
      groups_sum = (END_BITS + 1)'(end_cap) + (END_BITS + 1)'(7);
      rot = x_ff[ORIGIN_BITS-1:0] - cfg.origin_x;
      pat_twice = {pat_ff, pat_ff} >> rot;
   end

   assign busy   = state_ff != FR_IDLE;
   assign accept = start && !busy;

   assign ram_wr_en   = accept && command == CMD_LOAD &&
                        ROWS_CMP'(row_slot) < ROWS_CMP'(PATTERN_ROWS);
   assign ram_wr_addr = ROW_BITS'(row_slot);
   assign ram_wr_data = pattern_word;
   assign ram_rd_addr = ROW_BITS'(row_hb);

   assign push_entry.base     = p_ff[ADDR_BITS+2:3];
   assign push_entry.offset   = p_ff[2:0];
   assign push_entry.span_end = end_cap;
   assign push_entry.groups   = groups_sum[COUNT_BITS+2:3];
   assign push_entry.pattern  = pat_twice[WORD_BITS-1:0];

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      w_in      = w_ff;
      num_in    = num_ff;
      neg_in    = neg_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      p_in      = p_ff;
      pat_in    = pat_ff;
      ram_rd_en = 1'b0;
      push      = 1'b0;
      unique case (state_ff)
         FR_IDLE: begin
            if (accept && command == CMD_FILL && w_sat != '0) begin
               x_in    = span_x;
               y_in    = span_y;
               w_in    = w_sat;
               neg_in  = span_y < cfg.origin_y;
               num_in  = (span_y < cfg.origin_y) ? cfg.origin_y - span_y
                                                 : span_y - cfg.origin_y;
               rem_in  = '0;
               step_in = STEP_BITS'(COORD_BITS - 1);
               state_in = FR_DIVIDE;
            end
         end
         FR_DIVIDE: begin
            p_in   = PIXEL_BITS'(y_ff) * PIXEL_BITS'(cfg.line_pitch) + PIXEL_BITS'(x_ff);
            num_in = num_ff << 1;
            rem_in = (shifted >= (HB + 1)'(h_eff)) ? HB'(shifted - (HB + 1)'(h_eff))
                                                   : HB'(shifted);
            if (step_ff == '0) begin
               state_in = FR_LOOKUP;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         FR_LOOKUP: begin
            ram_rd_en = 1'b1;
            state_in  = FR_FETCH;
         end
         FR_FETCH: begin
            pat_in   = ram_rd_data;
            state_in = FR_PUSH;
         end
         FR_PUSH: begin
            if (!queue_full) begin
               push     = 1'b1;
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      w_ff    <= w_in;
      num_ff  <= num_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      p_ff    <= p_in;
      pat_ff  <= pat_in;
   end
endmodule

[design/mpse_queue.sv]
// two entry span queue between front and back
module mpse_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mpse_pkg::span_type push_entry,
   output logic               full,
   input  logic               pop,
   output mpse_pkg::span_type head,
   output logic               empty
);
   import mpse_pkg::*;

   span_type   entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end
endmodule

[design/mpse_back.sv]
// back end: walks a span one byte group per cycle and drives the result beat
module mpse_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              transparent_mode,
   input  logic                              queue_empty,
   output logic                              pop,
   input  mpse_pkg::span_type                head,
   output logic                              rsp_valid,
   output logic [mpse_pkg::ADDR_BITS-1:0]    rsp_group_address,
   output logic [7:0]                        rsp_fg_pixels,
   output logic [7:0]                        rsp_bg_pixels,
   output logic                              rsp_last_group
);
   import mpse_pkg::*;

   span_type              cur_ff, cur_in;
   logic                  active_ff, active_in;
   logic [GROUP_BITS-1:0] g_ff, g_in;
   logic                  valid_ff, last_ff;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [7:0]            fg_ff, fg_in, bg_ff, bg_in;
   logic                  last;

   always_comb begin
      logic [POS_BITS-1:0]    pos;
      logic [ORIGIN_BITS-1:0] idx;
      logic                   in_span;
      logic                   bit_val;
      fg_in = '0;
      bg_in = '0;
      for (int i = 0; i < 8; i++) begin
         pos     = {g_ff, 3'(i)};
         in_span = pos >= POS_BITS'(cur_ff.offset) && END_BITS'(pos) < cur_ff.span_end;
         idx     = pos[ORIGIN_BITS-1:0] - ORIGIN_BITS'(cur_ff.offset);
         bit_val = cur_ff.pattern[idx];
         fg_in[7-i] = in_span && bit_val;
         bg_in[7-i] = in_span && !bit_val && !transparent_mode;
      end
      addr_in = cur_ff.base + ADDR_BITS'(g_ff);
      last    = COUNT_BITS'(g_ff) + 1'b1 == cur_ff.groups;
      pop     = (!active_ff || last) && !queue_empty;
      cur_in  = pop ? head : cur_ff;
      g_in    = pop ? '0 : g_ff + 1'b1;
      active_in = pop || (active_ff && !last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= active_ff;
         last_ff   <= active_ff && last;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      g_ff    <= g_in;
      addr_ff <= addr_in;
      fg_ff   <= fg_in;
      bg_ff   <= bg_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_group_address = addr_ff;
   assign rsp_fg_pixels     = fg_ff;
   assign rsp_bg_pixels     = bg_ff;
   assign rsp_last_group    = last_ff;
endmodule

[design/mono_pattern_span_expander.sv]
// top level of the monochrome stipple span expander
// load: written on accept, busy stays low; span: busy until pushed, more while the queue is full
// idle back end: first group beat comes via queue, span and result registers, then one per cycle
// a span passes the front end (11-step row remainder loop, row read, push), then the back end
// group by group; a 2-entry queue lets the two overlap, so spans pace at the slower of the two
// sync reset initialises control and csr registers; stipple rows are undefined until loaded
module mono_pattern_span_expander #(
   parameter int PATTERN_ROWS = 32,
   parameter int MAX_SPAN     = 504
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_command,
   input  logic [mpse_pkg::SLOT_BITS-1:0]         req_row_slot,
   input  logic [mpse_pkg::WORD_BITS-1:0]         req_pattern_word,
   input  logic [mpse_pkg::COORD_BITS-1:0]        req_span_x,
   input  logic [mpse_pkg::COORD_BITS-1:0]        req_span_y,
   input  logic [mpse_pkg::WIDTH_BITS-1:0]        req_span_width,
   output logic                                   rsp_valid,
   output logic [mpse_pkg::ADDR_BITS-1:0]         rsp_group_address,
   output logic [7:0]                             rsp_fg_pixels,
   output logic [7:0]                             rsp_bg_pixels,
   output logic                                   rsp_last_group,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mpse_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [mpse_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import mpse_pkg::*;

   localparam int ROW_BITS = PATTERN_ROWS > 1 ? $clog2(PATTERN_ROWS) : 1;

   cfg_type              cfg_ff, cfg_in;
   logic                 ram_wr_en, ram_rd_en;
   logic [ROW_BITS-1:0]  ram_wr_addr, ram_rd_addr;
   logic [WORD_BITS-1:0] ram_wr_data, ram_rd_data;
   logic                 push, queue_full, queue_empty, pop;
   span_type             push_entry, head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LINE_PITCH:  cfg_in.line_pitch       = csr_wdata[PITCH_BITS-1:0];
            CSR_TRANSPARENT: cfg_in.transparent_mode = csr_wdata[0];
            CSR_HEIGHT:      cfg_in.pattern_height   = csr_wdata[HEIGHT_BITS-1:0];
            CSR_ORIGIN_X:    cfg_in.origin_x         = csr_wdata[ORIGIN_BITS-1:0];
            CSR_ORIGIN_Y:    cfg_in.origin_y         = csr_wdata[COORD_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_pitch       <= PITCH_RESET;
         cfg_ff.transparent_mode <= 1'b0;
         cfg_ff.pattern_height   <= HEIGHT_RESET;
         cfg_ff.origin_x         <= '0;
         cfg_ff.origin_y         <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mpse_front #(
      .PATTERN_ROWS (PATTERN_ROWS),
      .MAX_SPAN     (MAX_SPAN)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .start        (start),
      .busy         (busy),
      .command      (req_command),
      .row_slot     (req_row_slot),
      .pattern_word (req_pattern_word),
      .span_x       (req_span_x),
      .span_y       (req_span_y),
      .span_width   (req_span_width),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .push         (push),
      .push_entry   (push_entry),
      .queue_full   (queue_full)
   );

   mpse_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (PATTERN_ROWS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mpse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .empty      (queue_empty)
   );

   mpse_back u_back (
      .clock             (clock),
      .reset             (reset),
      .transparent_mode  (cfg_ff.transparent_mode),
      .queue_empty       (queue_empty),
      .pop               (pop),
      .head              (head),
      .rsp_valid         (rsp_valid),
      .rsp_group_address (rsp_group_address),
      .rsp_fg_pixels     (rsp_fg_pixels),
      .rsp_bg_pixels     (rsp_bg_pixels),
      .rsp_last_group    (rsp_last_group)
   );
endmodule

[design/mpse_checker.sv]
// port level checks for the span expander and their bind
module mpse_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input logic [mpse_pkg::ADDR_BITS-1:0]      rsp_group_address,
   input logic [7:0]                          rsp_fg_pixels,
   input logic [7:0]                          rsp_bg_pixels,
   input logic                                rsp_last_group
);
   import mpse_pkg::*;

   busy_needs_accept: assert property (@(posedge clock) disable iff (reset)
      busy |-> $past(busy) || $past(start))
      else $error("busy raised without an accepted beat");

   last_only_on_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_last_group |-> rsp_valid)
      else $error("last group flag outside a result beat");

   masks_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fg_pixels & rsp_bg_pixels) == 8'd0)
      else $error("pixel marked both foreground and background");

   groups_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_group |=> rsp_valid &&
         rsp_group_address == ADDR_BITS'($past(rsp_group_address) + 1'b1))
      else $error("span groups not emitted back to back");
endmodule

bind mono_pattern_span_expander mpse_checker u_checker (.*);
